// ===== src/skjwt_pkg.sv =====
// Package for the skeleton joint world transform unit.
// Holds sizes and field widths shared by the channel interfaces and the top level.
// No dependencies.
`default_nettype none
package skjwt_pkg;
  localparam int MAX_JOINTS = 64;
  localparam int JCW        = $clog2(MAX_JOINTS + 1);
  localparam int WPJ        = 12;
  localparam int MAW        = $clog2(MAX_JOINTS * WPJ);
  localparam int PIW        = 6;
  localparam int POSW       = 32;
  localparam int QW         = 16;
  localparam int RW         = 18;
endpackage
`default_nettype wire

// ===== src/skjwt_if.sv =====
// Channel interfaces for joint transactions in and world matrix transactions out.
// Depends on skjwt_pkg.
`default_nettype none
interface skjwt_in_if;
  import skjwt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   first_joint;
  logic                   has_parent;
  logic [PIW-1:0]         parent_index;
  logic signed [POSW-1:0] pos_x;
  logic signed [POSW-1:0] pos_y;
  logic signed [POSW-1:0] pos_z;
  logic signed [QW-1:0]   quat_x;
  logic signed [QW-1:0]   quat_y;
  logic signed [QW-1:0]   quat_z;
  modport source(output valid, first_joint, has_parent, parent_index, pos_x, pos_y, pos_z,
                 quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, first_joint, has_parent, parent_index, pos_x, pos_y, pos_z,
               quat_x, quat_y, quat_z, output ready);
endinterface

interface skjwt_out_if;
  import skjwt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [RW-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [POSW-1:0] tx, ty, tz;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
               output ready);
endinterface
`default_nettype wire

// ===== src/skeleton_joint_world_transform_unit.sv =====
// Top level of the skeleton joint world transform unit: sequencer, shared
// multiplier, square root step and world matrix store. Depends on skjwt_pkg
// and the channel interfaces in skjwt_if.sv.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | joint flags, parent index, position, quaternion x,y,z
//   out_ch   | out | valid/ready        | 3x3 world rotation (Q2.16), translation (Q16.16)
//
// A joint is taken only while the sequencer is idle; a root joint passes the squares, square
// root, w products, local entries, copy and store write, and a joint with a parent reads its
// parent and composes in place of the copy. The work is set by the single 18x32 multiplier
// (6 + 3 products, plus 36 for the parent compose), the square root (load, 16 steps, negate),
// the 9 local entries and the 12-word read and write of the store.
// Reset (rst_n, synchronous, active low) clears the sequencer, the joint count and the
// output valid; the store itself is not cleared and needs no clearing pass.
// A result waits in its own output register, so the next transaction is taken while
// the previous result is still stalled; the unit only blocks if a second result is ready.
`default_nettype none
module skeleton_joint_world_transform_unit (
  input  logic        clk,
  input  logic        rst_n,
  skjwt_in_if.sink    in_ch,
  skjwt_out_if.source out_ch
);
  import skjwt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_WP, S_LOC, S_CPY, S_RD, S_MAC, S_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] { MP_SQ, MP_W, MP_MAC } mph_t;

  typedef struct packed {
    mph_t       ph;
    logic [3:0] idx;
    logic [1:0] row;
    logic [1:0] col;
  } mtag_t;

  localparam logic signed [34:0] ONE_Q230 = 35'sd1 << 30;

  // Saturate a wide signed value to the rotation or translation width.
  function automatic logic signed [RW-1:0] sat_rot(input logic signed [52:0] v);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = (53'sd1 <<< (RW - 1)) - 53'sd1;
    lo = -hi - 53'sd1;
    if (v > hi) return hi[RW-1:0];
    else if (v < lo) return lo[RW-1:0];
    else return v[RW-1:0];
  endfunction

  function automatic logic signed [POSW-1:0] sat_pos(input logic signed [52:0] v);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = (53'sd1 <<< (POSW - 1)) - 53'sd1;
    lo = -hi - 53'sd1;
    if (v > hi) return hi[POSW-1:0];
    else if (v < lo) return lo[POSW-1:0];
    else return v[POSW-1:0];
  endfunction

  // Control state.
  state_t          state_r;
  logic [4:0]      cnt_r;
  logic [1:0]      row_r, col_r, kk_r;
  logic [JCW-1:0]  loaded_r, cur_idx_r;
  logic            root_r;
  logic            out_valid_r;
  logic            mv_r;
  mtag_t           tag_r;

  // Datapath registers.
  logic [PIW-1:0]          pidx_r;
  logic signed [POSW-1:0]  pos_r [3];
  logic signed [QW-1:0]    q_r [3];
  logic signed [31:0]      pp_r [6];
  logic signed [31:0]      wp_r [3];
  logic [30:0]             sq_v_r;
  logic [31:0]             sq_root_r;
  logic [30:0]             sq_bit_r;
  logic signed [QW-1:0]    w_r;
  logic signed [RW-1:0]    rl_r [9];
  logic [31:0]             par_r [WPJ];
  logic signed [RW-1:0]    rw_r [9];
  logic signed [POSW-1:0]  tw_r [3];
  logic signed [52:0]      acc_r;
  logic signed [49:0]      prod_r;
  logic [31:0]             rdata_r;
  logic signed [RW-1:0]    om_r [9];
  logic signed [POSW-1:0]  ot_r [3];

  logic [31:0] mem [MAX_JOINTS * WPJ];

  // Handshake and accept.
  logic in_acc, out_acc, out_load;
  logic [JCW-1:0] loaded_eff;
  logic parent_ok;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;
  // The finished matrix moves to the output register once that register is free.
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign loaded_eff  = in_ch.first_joint ? '0 : loaded_r;
  assign parent_ok   = in_ch.has_parent
                    && (32'(in_ch.parent_index) < 32'(loaded_eff))
                    && (32'(in_ch.parent_index) < 32'(MAX_JOINTS));

  // Shared multiplier operands.
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_go;
  mtag_t              tag_nxt;
  logic [3:0]         par_i, rl_i;
  assign par_i = {1'b0, row_r, 1'b0} + {2'b00, row_r} + {2'b00, kk_r};
  assign rl_i  = {1'b0, kk_r, 1'b0} + {2'b00, kk_r} + {2'b00, col_r};

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_go  = 1'b0;
    tag_nxt = '{ph: MP_SQ, idx: cnt_r[3:0], row: row_r, col: col_r};
    case (state_r)
      S_SQ: begin
        mul_go = 1'b1;
        case (cnt_r[2:0])
          3'd0: begin mul_a = 18'(q_r[0]); mul_b = 32'(q_r[0]); end
          3'd1: begin mul_a = 18'(q_r[1]); mul_b = 32'(q_r[1]); end
          3'd2: begin mul_a = 18'(q_r[2]); mul_b = 32'(q_r[2]); end
          3'd3: begin mul_a = 18'(q_r[0]); mul_b = 32'(q_r[1]); end
          3'd4: begin mul_a = 18'(q_r[0]); mul_b = 32'(q_r[2]); end
          default: begin mul_a = 18'(q_r[1]); mul_b = 32'(q_r[2]); end
        endcase
      end
      S_WP: begin
        mul_go      = 1'b1;
        tag_nxt.ph  = MP_W;
        mul_a       = 18'(w_r);
        mul_b       = 32'(q_r[cnt_r[1:0]]);
      end
      S_MAC: begin
        mul_go      = 1'b1;
        tag_nxt.ph  = MP_MAC;
        tag_nxt.idx = {2'b00, kk_r};
        mul_a       = $signed(par_r[par_i][RW-1:0]);
        mul_b       = (col_r == 2'd3) ? pos_r[kk_r] : 32'(rl_r[rl_i]);
      end
      default: ;
    endcase
  end

  // Accumulate for the parent compose. The rounding half is folded into the start value.
  logic signed [52:0] base;
  logic signed [52:0] acc_nxt;
  logic signed [52:0] acc_sh;
  assign base    = 53'sd32768 + ((tag_r.col == 2'd3)
                 ? (53'($signed(par_r[4'd9 + {2'b00, tag_r.row}])) <<< 16) : 53'sd0);
  assign acc_nxt = ((tag_r.idx == 4'd0) ? base : acc_r) + 53'(prod_r);
  assign acc_sh  = acc_nxt >>> 16;

  // Square root step.
  logic signed [34:0] rad;
  logic [32:0]        sq_sum;
  assign rad    = ONE_Q230 - 35'(pp_r[0]) - 35'(pp_r[1]) - 35'(pp_r[2]);
  assign sq_sum = 33'(sq_root_r) + 33'(sq_bit_r);

  // Local rotation entry in Q2.30, one per cycle.
  logic signed [34:0] lv;
  logic signed [52:0] lr;
  always_comb begin
    case (cnt_r[3:0])
      4'd0: lv = ONE_Q230 - 35'sd2 * (35'(pp_r[1]) + 35'(pp_r[2]));
      4'd1: lv = 35'sd2 * (35'(pp_r[3]) - 35'(wp_r[2]));
      4'd2: lv = 35'sd2 * (35'(pp_r[4]) + 35'(wp_r[1]));
      4'd3: lv = 35'sd2 * (35'(pp_r[3]) + 35'(wp_r[2]));
      4'd4: lv = ONE_Q230 - 35'sd2 * (35'(pp_r[0]) + 35'(pp_r[2]));
      4'd5: lv = 35'sd2 * (35'(pp_r[5]) - 35'(wp_r[0]));
      4'd6: lv = 35'sd2 * (35'(pp_r[4]) - 35'(wp_r[1]));
      4'd7: lv = 35'sd2 * (35'(pp_r[5]) + 35'(wp_r[0]));
      default: lv = ONE_Q230 - 35'sd2 * (35'(pp_r[0]) + 35'(pp_r[1]));
    endcase
  end
  assign lr = (53'(lv) + 53'sd8192) >>> 14;

  // Store addresses and the word to write.
  logic [MAW-1:0] raddr, waddr;
  logic [31:0]    wword [WPJ];
  logic           store_ok;
  assign raddr    = MAW'(pidx_r) * MAW'(WPJ) + MAW'(cnt_r);
  assign waddr    = MAW'(cur_idx_r) * MAW'(WPJ) + MAW'(cnt_r);
  assign store_ok = 32'(cur_idx_r) < 32'(MAX_JOINTS);
  always_comb begin
    for (int i = 0; i < 9; i++) wword[i] = 32'(rw_r[i]);
    for (int i = 0; i < 3; i++) wword[9 + i] = tw_r[i];
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      kk_r        <= '0;
      loaded_r    <= '0;
      cur_idx_r   <= '0;
      root_r      <= 1'b1;
      out_valid_r <= 1'b0;
      mv_r        <= 1'b0;
      tag_r       <= '{ph: MP_SQ, idx: 4'd0, row: 2'd0, col: 2'd0};
    end else begin
      mv_r  <= mul_go;
      tag_r <= tag_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            loaded_r  <= loaded_eff;
            cur_idx_r <= loaded_eff;
            root_r    <= !parent_ok;
            cnt_r     <= '0;
            state_r   <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r == 5'd5) begin
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          if (cnt_r == 5'd17) begin
            cnt_r   <= '0;
            state_r <= S_WP;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_WP: begin
          if (cnt_r == 5'd2) begin
            cnt_r   <= '0;
            state_r <= S_LOC;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_LOC: begin
          if (cnt_r == 5'd8) begin
            cnt_r   <= '0;
            state_r <= root_r ? S_CPY : S_RD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_CPY: begin
          cnt_r   <= '0;
          state_r <= S_WR;
        end
        S_RD: begin
          if (cnt_r == 5'(WPJ)) begin
            cnt_r   <= '0;
            row_r   <= '0;
            col_r   <= '0;
            kk_r    <= '0;
            state_r <= S_MAC;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MAC: begin
          if (kk_r == 2'd2) begin
            kk_r  <= '0;
            col_r <= col_r + 2'd1;
            if (col_r == 2'd3) begin
              row_r <= row_r + 2'd1;
              if (row_r == 2'd2) begin
                cnt_r   <= '0;
                state_r <= S_WR;
              end
            end
          end else begin
            kk_r <= kk_r + 2'd1;
          end
        end
        S_WR: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(WPJ - 1)) begin
            if (store_ok) loaded_r <= cur_idx_r + JCW'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      pidx_r <= in_ch.parent_index;
      pos_r[0] <= in_ch.pos_x;
      pos_r[1] <= in_ch.pos_y;
      pos_r[2] <= in_ch.pos_z;
      q_r[0] <= in_ch.quat_x;
      q_r[1] <= in_ch.quat_y;
      q_r[2] <= in_ch.quat_z;
    end
    if (mv_r) begin
      case (tag_r.ph)
        MP_SQ: pp_r[tag_r.idx[2:0]] <= prod_r[31:0];
        MP_W:  wp_r[tag_r.idx[1:0]] <= prod_r[31:0];
        MP_MAC: begin
          acc_r <= acc_nxt;
          if (tag_r.idx == 4'd2) begin
            if (tag_r.col == 2'd3) tw_r[tag_r.row] <= sat_pos(acc_sh);
            else rw_r[{1'b0, tag_r.row, 1'b0} + {2'b00, tag_r.row} + {2'b00, tag_r.col}]
                   <= sat_rot(acc_sh);
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_SQRT) begin
      if (cnt_r == 5'd0) begin
        // A negative radicand gives w = 0.
        sq_v_r    <= rad[34] ? '0 : rad[30:0];
        sq_root_r <= '0;
        sq_bit_r  <= 31'd1 << 30;
      end else if (cnt_r == 5'd17) begin
        w_r <= QW'(17'd0 - {1'b0, sq_root_r[QW-1:0]});
      end else begin
        if (33'(sq_v_r) >= sq_sum) begin
          sq_v_r    <= 31'(33'(sq_v_r) - sq_sum);
          sq_root_r <= (sq_root_r >> 1) + 32'(sq_bit_r);
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
    end
    if (state_r == S_LOC) rl_r[cnt_r[3:0]] <= sat_rot(lr);
    if (state_r == S_CPY) begin
      rw_r <= rl_r;
      tw_r <= pos_r;
    end
    if (state_r == S_RD && cnt_r != 5'd0) par_r[cnt_r[3:0] - 4'd1] <= rdata_r;
    if (out_load) begin
      om_r <= rw_r;
      ot_r <= tw_r;
    end
  end

  // World matrix store, one word per cycle.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (state_r == S_WR && store_ok) mem[waddr] <= wword[cnt_r[3:0]];
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.m00 = om_r[0];
  assign out_ch.m01 = om_r[1];
  assign out_ch.m02 = om_r[2];
  assign out_ch.m10 = om_r[3];
  assign out_ch.m11 = om_r[4];
  assign out_ch.m12 = om_r[5];
  assign out_ch.m20 = om_r[6];
  assign out_ch.m21 = om_r[7];
  assign out_ch.m22 = om_r[8];
  assign out_ch.tx  = ot_r[0];
  assign out_ch.ty  = ot_r[1];
  assign out_ch.tz  = ot_r[2];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(loaded_r) <= 32'(MAX_JOINTS))
    else $error("joint count exceeds store depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("unit ready right after taking a joint");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && cnt_r == 5'(WPJ - 1) && store_ok)
      |=> loaded_r == $past(cur_idx_r) + JCW'(1))
    else $error("joint count not advanced after store");
  a_root_on_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> !root_r)
    else $error("root joint entered parent compose");
  a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && cnt_r == 5'd17) |-> sq_root_r <= 32'd32768)
    else $error("square root out of range");
`endif
endmodule
`default_nettype wire
